### rtl/core/crbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crbm_pkg
// shared widths and the side-band bundle carried beside the root pipeline
// ----------------------------------------------------------------------------
package crbm_pkg;

	// coordinate and datapath widths
	localparam int CW    = 16;         // coordinate field width
	localparam int MW    = CW + 1;     // magnitude width, holds 32768
	localparam int PRODW = 2 * CW - 1; // |c| * max|c| is at most 2^30
	localparam int SUMW  = 2 * CW;     // sum of three squares stays below 2^32
	localparam int ROOTW = SUMW / 2;   // root bits, one per sqrt stage
	localparam int REMW  = ROOTW + 2;  // partial remainder of the root
	localparam int QW    = CW;         // quotient bits, one per divide stage
	localparam int RW    = SUMW;       // divide remainder width
	localparam int NLANE = 3;

	// per-point data that rides along the square-root stages
	typedef struct packed {
		logic [NLANE-1:0][PRODW-1:0] prod;
		logic [NLANE-1:0]            neg;
		logic                        zero;
	} side_t;

endpackage

### rtl/core/cube_to_ball_radial_map_top.sv
`timescale 1ns / 1ps
// Maps a point of the cube onto the ball along its own ray: each coordinate is
// multiplied by the largest absolute coordinate and divided by the floor
// integer square root of the sum of squares, truncated toward zero; the zero
// point gives zero. One point enters per clock while the pipeline is not held.
// The pipeline has four front stages (magnitude, maximum, multiply, sum),
// sixteen square-root stages and sixteen divide stages, one bit each, and an
// output register. The whole pipeline holds while a result waits on m_tready.
// ----------------------------------------------------------------------------
// cube_to_ball_radial_map_top
// cube to ball radial projection, fully pipelined stream block
// ----------------------------------------------------------------------------
module cube_to_ball_radial_map_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // coord_x [15:0], coord_y [31:16], coord_z [47:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // mapped_x [15:0], mapped_y [31:16], mapped_z [47:32]
);

	logic                                         en;
	logic                                         f_valid, r_valid;
	logic [crbm_pkg::SUMW-1:0]                    f_sum;
	crbm_pkg::side_t                              f_side, r_side;
	logic [crbm_pkg::ROOTW-1:0]                   r_root;
	logic [crbm_pkg::NLANE-1:0][crbm_pkg::CW-1:0] coord, mapped;

	// pipeline advances unless the output holds an untaken result
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign coord    = s_tdata;
	assign m_tdata  = mapped;

	crbm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.coord     (coord),
		.out_valid (f_valid),
		.sum       (f_sum),
		.side      (f_side)
	);

	crbm_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.rad       (f_sum),
		.in_side   (f_side),
		.out_valid (r_valid),
		.root      (r_root),
		.out_side  (r_side)
	);

	crbm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (r_valid),
		.root_len  (r_root),
		.in_side   (r_side),
		.out_valid (m_tvalid),
		.mapped    (mapped)
	);

endmodule

### rtl/core/crbm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crbm_front
// magnitudes, largest magnitude, squares, products and sum of squares
// ----------------------------------------------------------------------------
module crbm_front (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        en,
	input  logic                                        in_valid,
	input  logic [crbm_pkg::NLANE-1:0][crbm_pkg::CW-1:0] coord,
	output logic                                        out_valid,
	output logic [crbm_pkg::SUMW-1:0]                   sum,
	output crbm_pkg::side_t                             side
);

	logic [3:0]                                         valid_q;
	logic [crbm_pkg::NLANE-1:0][crbm_pkg::MW-1:0]       mag_s1, mag_s2;
	logic [crbm_pkg::NLANE-1:0]                         neg_s1, neg_s2, neg_s3;
	logic [crbm_pkg::MW-1:0]                            mx_s2;
	logic [crbm_pkg::NLANE-1:0][crbm_pkg::PRODW-1:0]    sq_s3, prod_s3;
	logic [crbm_pkg::MW-1:0]                            mx01;
	logic [crbm_pkg::NLANE-1:0][2*crbm_pkg::MW-1:0]     sq_full, prod_full;
	logic [crbm_pkg::SUMW-1:0]                          sum_s4;
	crbm_pkg::side_t                                    side_s4;

	// valid bits, one per front stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[2:0], in_valid};
		end
	end

	// largest magnitude
	assign mx01 = (mag_s1[1] > mag_s1[0]) ? mag_s1[1] : mag_s1[0];

	// squares and products
	always_comb begin
		for (int i = 0; i < crbm_pkg::NLANE; i++) begin
			sq_full[i]   = mag_s2[i] * mag_s2[i];
			prod_full[i] = mag_s2[i] * mx_s2;
		end
	end

	// stages one to four
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < crbm_pkg::NLANE; i++) begin
				neg_s1[i] <= coord[i][crbm_pkg::CW-1];
				mag_s1[i] <= coord[i][crbm_pkg::CW-1]
					? crbm_pkg::MW'(-$signed({coord[i][crbm_pkg::CW-1], coord[i]}))
					: {1'b0, coord[i]};
				sq_s3[i]   <= sq_full[i][crbm_pkg::PRODW-1:0];
				prod_s3[i] <= prod_full[i][crbm_pkg::PRODW-1:0];
			end
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			mx_s2   <= (mag_s1[2] > mx01) ? mag_s1[2] : mx01;
			neg_s3  <= neg_s2;
			sum_s4  <= crbm_pkg::SUMW'(sq_s3[0]) + crbm_pkg::SUMW'(sq_s3[1])
				+ crbm_pkg::SUMW'(sq_s3[2]);
			side_s4.prod <= prod_s3;
			side_s4.neg  <= neg_s3;
			side_s4.zero <= (sq_s3[0] == '0) && (sq_s3[1] == '0) && (sq_s3[2] == '0);
		end
	end

	assign out_valid = valid_q[3];
	assign sum       = sum_s4;
	assign side      = side_s4;

endmodule

### rtl/core/crbm_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crbm_sqrt
// floor integer square root, one root bit per pipeline stage
// ----------------------------------------------------------------------------
module crbm_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [crbm_pkg::SUMW-1:0]   rad,
	input  crbm_pkg::side_t             in_side,
	output logic                        out_valid,
	output logic [crbm_pkg::ROOTW-1:0]  root,
	output crbm_pkg::side_t             out_side
);

	localparam int N = crbm_pkg::ROOTW;

	logic [N:0]                   valid_s;
	logic [crbm_pkg::SUMW-1:0]    rad_s  [0:N];
	logic [crbm_pkg::REMW-1:0]    rem_s  [0:N];
	logic [crbm_pkg::ROOTW-1:0]   root_s [0:N];
	crbm_pkg::side_t              side_s [0:N];

	// stage zero is the input
	assign valid_s[0] = in_valid;
	assign rad_s[0]   = rad;
	assign rem_s[0]   = '0;
	assign root_s[0]  = '0;
	assign side_s[0]  = in_side;

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [crbm_pkg::REMW-1:0] cur, trial;
		logic                      take;

		// bring down two radicand bits and try the next root bit
		assign cur   = {rem_s[k][crbm_pkg::REMW-3:0],
			rad_s[k][crbm_pkg::SUMW-1 -: 2]};
		assign trial = {root_s[k], 2'b01};
		assign take  = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= {rad_s[k][crbm_pkg::SUMW-3:0], 2'b00};
				rem_s[k+1]  <= take ? cur - trial : cur;
				root_s[k+1] <= {root_s[k][crbm_pkg::ROOTW-2:0], take};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = valid_s[N];
	assign root      = root_s[N];
	assign out_side  = side_s[N];

endmodule

### rtl/core/crbm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crbm_div
// three-lane restoring divide, one quotient bit per stage, then sign apply
// ----------------------------------------------------------------------------
module crbm_div (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         en,
	input  logic                                         in_valid,
	input  logic [crbm_pkg::ROOTW-1:0]                   root_len,
	input  crbm_pkg::side_t                              in_side,
	output logic                                         out_valid,
	output logic [crbm_pkg::NLANE-1:0][crbm_pkg::CW-1:0] mapped
);

	localparam int N = crbm_pkg::QW;

	logic [N:0]                                        valid_s;
	logic [crbm_pkg::ROOTW-1:0]                        d_s   [0:N];
	logic [crbm_pkg::NLANE-1:0][crbm_pkg::RW-1:0]      r_s   [0:N];
	logic [crbm_pkg::NLANE-1:0][crbm_pkg::QW-1:0]      q_s   [0:N];
	logic [crbm_pkg::NLANE-1:0]                        neg_s [0:N];
	logic [N:0]                                        zero_s;
	logic                                              valid_o_q;
	logic [crbm_pkg::NLANE-1:0][crbm_pkg::CW-1:0]      mapped_q;

	// stage zero is the input
	assign valid_s[0] = in_valid;
	assign d_s[0]     = root_len;
	assign neg_s[0]   = in_side.neg;
	assign zero_s[0]  = in_side.zero;
	assign q_s[0]     = '0;
	always_comb begin
		for (int i = 0; i < crbm_pkg::NLANE; i++) begin
			r_s[0][i] = crbm_pkg::RW'(in_side.prod[i]);
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_bit
		localparam int SH = N - 1 - k;
		logic [crbm_pkg::RW-1:0]    dsh;
		logic [crbm_pkg::NLANE-1:0] take;

		// compare each remainder with the divisor at this bit weight
		assign dsh = crbm_pkg::RW'(d_s[k]) << SH;
		always_comb begin
			for (int i = 0; i < crbm_pkg::NLANE; i++) begin
				take[i] = r_s[k][i] >= dsh;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < crbm_pkg::NLANE; i++) begin
					r_s[k+1][i] <= take[i] ? r_s[k][i] - dsh : r_s[k][i];
					q_s[k+1][i] <= {q_s[k][i][crbm_pkg::QW-2:0], take[i]};
				end
				d_s[k+1]    <= d_s[k];
				neg_s[k+1]  <= neg_s[k];
				zero_s[k+1] <= zero_s[k];
			end
		end
	end

	// output register: restore signs, zero point passes as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o_q <= 1'b0;
		end else if (en) begin
			valid_o_q <= valid_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < crbm_pkg::NLANE; i++) begin
				if (zero_s[N]) begin
					mapped_q[i] <= '0;
				end else if (neg_s[N][i]) begin
					mapped_q[i] <= crbm_pkg::CW'(-q_s[N][i]);
				end else begin
					mapped_q[i] <= crbm_pkg::CW'(q_s[N][i]);
				end
			end
		end
	end

	assign out_valid = valid_o_q;
	assign mapped    = mapped_q;

endmodule
